@@ hw/rtl/apl_pkg.sv @@
// Shared types, codes and widths of the auto pointer layer controller.
package apl_pkg;

    // Default values of the top-level parameters.
    localparam int KEY_POSITIONS_DEF = 64;
    localparam int NUM_LAYERS_DEF    = 32;
    localparam int TIME_BITS_DEF     = 16;

    // Fixed field widths.
    localparam int REQ_W      = 3;
    localparam int POS_W      = 6;
    localparam int LAYER_W    = 5;
    localparam int COUNT_W    = 16;
    localparam int IDLE_CFG_W = 15;
    localparam int MASK_W     = 64;
    localparam int CHG_W      = 2;

    // Port widths.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = MASK_W;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = REQ_W;
    localparam int M_TDATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_IDLE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PTR_REARM  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXCL_MASK  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REARM_MASK = 2'd3;

    // Event kinds.
    localparam logic [REQ_W-1:0] REQ_MOTION    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_KEY_POS   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_KEYCODE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LAYER_CHG = 3'd4;

    // Layer change codes.
    localparam logic [CHG_W-1:0] CHG_NONE = 2'd0;
    localparam logic [CHG_W-1:0] CHG_ON   = 2'd1;
    localparam logic [CHG_W-1:0] CHG_OFF  = 2'd2;

    typedef struct packed {
        logic [IDLE_CFG_W-1:0] key_idle_before_on_ms;
        logic [IDLE_CFG_W-1:0] pointer_idle_rearm_ms;
        logic [MASK_W-1:0]     excluded_key_mask;
        logic [MASK_W-1:0]     rearm_key_mask;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [POS_W-1:0]   key_position;
        logic [LAYER_W-1:0] target_layer;
        logic [COUNT_W-1:0] off_timeout_ms;
        logic               layer_still_on;
    } ev_t;

    typedef struct packed {
        logic [LAYER_W-1:0] current_layer;
        logic               layer_on;
        logic [CHG_W-1:0]   change;
        logic               status;
    } res_t;

endpackage

@@ hw/rtl/apl_cfg_regs.sv @@
// Configuration register file of the auto pointer layer controller.
module apl_cfg_regs
    import apl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_KEY_IDLE:
                begin
                    cfg_reg.key_idle_before_on_ms <= cfg_wdata[IDLE_CFG_W-1:0];
                end
                REG_PTR_REARM:
                begin
                    cfg_reg.pointer_idle_rearm_ms <= cfg_wdata[IDLE_CFG_W-1:0];
                end
                REG_EXCL_MASK:
                begin
                    cfg_reg.excluded_key_mask <= cfg_wdata[MASK_W-1:0];
                end
                REG_REARM_MASK:
                begin
                    cfg_reg.rearm_key_mask <= cfg_wdata[MASK_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/apl_core.sv @@
// Controller state and the per-event update logic.
module apl_core
    import apl_pkg::*;
#(
    parameter int KEY_POSITIONS = KEY_POSITIONS_DEF,
    parameter int NUM_LAYERS    = NUM_LAYERS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  ev_t  ev,
    input  cfg_t cfg,
    output res_t res
);

    localparam int CMP_W = (TIME_BITS > IDLE_CFG_W) ? TIME_BITS : IDLE_CFG_W;

    logic [LAYER_W-1:0]   toggle_layer_reg, toggle_layer_next;
    logic                 active_reg, active_next;
    logic                 rearm_wait_reg, rearm_wait_next;
    logic [TIME_BITS-1:0] since_key_reg, since_key_next;
    logic [TIME_BITS-1:0] since_ptr_reg, since_ptr_next;
    logic [COUNT_W-1:0]   countdown_reg, countdown_next;

    logic             key_idle_ok;
    logic             ptr_idle_ok;
    logic             layer_ok;
    logic             pos_ok;
    logic             pos_excluded;
    logic             pos_rearm;
    logic [CHG_W-1:0] chg;
    logic             bad_layer;

    // A saturated idle counter counts as idle for any required time.
    assign key_idle_ok = (since_key_reg == '1) ||
                         (CMP_W'(since_key_reg) >= CMP_W'(cfg.key_idle_before_on_ms));
    assign ptr_idle_ok = (since_ptr_reg == '1) ||
                         (CMP_W'(since_ptr_reg) >= CMP_W'(cfg.pointer_idle_rearm_ms));

    assign layer_ok     = {1'b0, ev.target_layer} < (LAYER_W + 1)'(NUM_LAYERS);
    assign pos_ok       = {1'b0, ev.key_position} < (POS_W + 1)'(KEY_POSITIONS);
    assign pos_excluded = pos_ok && cfg.excluded_key_mask[ev.key_position];
    assign pos_rearm    = pos_ok && cfg.rearm_key_mask[ev.key_position];

    always_comb
    begin
        toggle_layer_next = toggle_layer_reg;
        active_next       = active_reg;
        rearm_wait_next   = rearm_wait_reg;
        since_key_next    = since_key_reg;
        since_ptr_next    = since_ptr_reg;
        countdown_next    = countdown_reg;
        chg               = CHG_NONE;
        bad_layer         = 1'b0;

        unique case (ev.req_type)
            REQ_MOTION:
            begin
                if (!layer_ok)
                begin
                    bad_layer = 1'b1;
                end
                else
                begin
                    toggle_layer_next = ev.target_layer;
                    since_ptr_next    = '0;
                    // While the hold-off is still running, motion only updates the
                    // layer and restarts the pointer idle count.
                    if (!rearm_wait_reg || ptr_idle_ok)
                    begin
                        rearm_wait_next = 1'b0;
                        if (!active_reg && key_idle_ok)
                        begin
                            active_next = 1'b1;
                            chg         = CHG_ON;
                        end
                        if (ev.off_timeout_ms != '0)
                        begin
                            countdown_next = ev.off_timeout_ms;
                        end
                    end
                end
            end
            REQ_KEY_POS:
            begin
                if (active_reg && pos_rearm)
                begin
                    rearm_wait_next = 1'b1;
                    since_ptr_next  = '0;
                end
                if (active_reg && !pos_excluded)
                begin
                    active_next = 1'b0;
                    chg         = CHG_OFF;
                end
            end
            REQ_KEYCODE:
            begin
                since_key_next = '0;
            end
            REQ_TICK:
            begin
                if (since_key_reg != '1)
                begin
                    since_key_next = since_key_reg + 1'b1;
                end
                if (since_ptr_reg != '1)
                begin
                    since_ptr_next = since_ptr_reg + 1'b1;
                end
                if (countdown_reg != '0)
                begin
                    countdown_next = countdown_reg - 1'b1;
                    if ((countdown_reg == COUNT_W'(1)) && active_reg)
                    begin
                        active_next = 1'b0;
                        chg         = CHG_OFF;
                    end
                end
            end
            REQ_LAYER_CHG:
            begin
                // An external turn-off is not reported as a change.
                if (!ev.layer_still_on)
                begin
                    active_next    = 1'b0;
                    countdown_next = '0;
                end
            end
            default:
            begin
                chg = CHG_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_layer_reg <= '0;
            active_reg       <= 1'b0;
            rearm_wait_reg   <= 1'b0;
            since_key_reg    <= '1;
            since_ptr_reg    <= '1;
            countdown_reg    <= '0;
        end
        else if (fire)
        begin
            toggle_layer_reg <= toggle_layer_next;
            active_reg       <= active_next;
            rearm_wait_reg   <= rearm_wait_next;
            since_key_reg    <= since_key_next;
            since_ptr_reg    <= since_ptr_next;
            countdown_reg    <= countdown_next;
        end
    end

    assign res.current_layer = toggle_layer_next;
    assign res.layer_on      = active_next;
    assign res.change        = chg;
    assign res.status        = bad_layer;

endmodule

@@ hw/rtl/auto_pointer_layer_controller_top.sv @@
// Top level of the auto pointer layer controller: input and result stages.
//
//  Port group | Direction | Beat contents
//  -----------+-----------+------------------------------------------------------
//  s_*        | in        | tuser: req_type; tdata: key_position, target_layer,
//             |           | off_timeout_ms, layer_still_on
//  m_*        | out       | tdata: current_layer, layer_on, change, status
//  cfg_*      | in        | register write: index in cfg_addr, value in cfg_wdata
//
// One event per cycle is sustained while m_tready stays high; an accepted beat goes
// through the input register, then the update logic into the result register. The
// state update happens in the same cycle that loads the result register. Reset clears
// state to idle with both idle counters saturated. A stall on m_tready holds the
// result; s_tready drops only when both stages are full.
module auto_pointer_layer_controller_top
    import apl_pkg::*;
#(
    parameter int KEY_POSITIONS = KEY_POSITIONS_DEF,
    parameter int NUM_LAYERS    = NUM_LAYERS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] key_position, [10:6] target_layer, [26:11] off_timeout_ms,
    // [27] layer_still_on, [31:28] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [2:0] req_type
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [4:0] current_layer, [5] layer_on, [7:6] change, [8] status, [15:9] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;
    ev_t  s_ev;
    res_t core_res;

    logic in_valid_reg, in_valid_next;
    ev_t  in_ev_reg;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    logic advance;
    logic fire;

    apl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    apl_core #(
        .KEY_POSITIONS (KEY_POSITIONS),
        .NUM_LAYERS    (NUM_LAYERS),
        .TIME_BITS     (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (in_ev_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    assign s_ev.req_type       = s_tuser[REQ_W-1:0];
    assign s_ev.key_position   = s_tdata[5:0];
    assign s_ev.target_layer   = s_tdata[10:6];
    assign s_ev.off_timeout_ms = s_tdata[26:11];
    assign s_ev.layer_still_on = s_tdata[27];

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ev_reg <= s_ev;
        end
        if (fire)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg.status, out_res_reg.change,
                       out_res_reg.layer_on, out_res_reg.current_layer};

    // Turning the layer on must leave it on in the same result.
    a_on_reports_on: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.change == CHG_ON)) |-> out_res_reg.layer_on)
        else $error("activation result shows layer off");

    a_off_reports_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.change == CHG_OFF)) |-> !out_res_reg.layer_on)
        else $error("deactivation result shows layer on");

    // A rejected layer never changes the layer state.
    a_bad_layer_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.status) |-> (out_res_reg.change == CHG_NONE))
        else $error("bad layer result reports a change");

    // Input backpressure only comes from a full, stalled result stage.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule

@@ tb/sv/auto_pointer_layer_controller_top_test.sv @@
// Self-checking testbench of the auto pointer layer controller with its own layer-state scoreboard.
`timescale 1ns / 1ps

module auto_pointer_layer_controller_top_test;
    import apl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Tracks the controller state and holds the results still to come out.
    class layer_result_board;
        logic [IDLE_CFG_W-1:0] key_need_ms;
        logic [IDLE_CFG_W-1:0] rearm_need_ms;
        logic [MASK_W-1:0]     excl_mask;
        logic [MASK_W-1:0]     rearm_mask;

        logic [LAYER_W-1:0] layer_q;
        logic               on_q;
        logic               rearm_wait_q;
        logic [COUNT_W-1:0] key_idle_ms;
        logic [COUNT_W-1:0] ptr_idle_ms;
        logic [COUNT_W-1:0] off_left_ms;

        res_t expected_results[$];
        int   errors;
        int   results_seen;

        function new();
            key_need_ms   = '0;
            rearm_need_ms = '0;
            excl_mask     = '0;
            rearm_mask    = '0;
            layer_q       = '0;
            on_q          = 1'b0;
            rearm_wait_q  = 1'b0;
            key_idle_ms   = '1;
            ptr_idle_ms   = '1;
            off_left_ms   = '0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_KEY_IDLE:   key_need_ms   = value[IDLE_CFG_W-1:0];
                REG_PTR_REARM:  rearm_need_ms = value[IDLE_CFG_W-1:0];
                REG_EXCL_MASK:  excl_mask     = value;
                REG_REARM_MASK: rearm_mask    = value;
                default: ;
            endcase
        endfunction

        // A saturated counter satisfies any requirement.
        function bit idle_enough(logic [COUNT_W-1:0] cnt, logic [IDLE_CFG_W-1:0] need);
            return (cnt == '1) || (cnt >= {1'b0, need});
        endfunction

        function res_t apply_event(ev_t ev);
            res_t r;
            r.change = CHG_NONE;
            r.status = 1'b0;
            case (ev.req_type)
                REQ_MOTION: begin
                    if (int'(ev.target_layer) >= NUM_LAYERS_DEF) begin
                        r.status = 1'b1;
                    end
                    else begin
                        layer_q = ev.target_layer;
                        if (rearm_wait_q && !idle_enough(ptr_idle_ms, rearm_need_ms)) begin
                            ptr_idle_ms = '0;
                        end
                        else begin
                            rearm_wait_q = 1'b0;
                            ptr_idle_ms  = '0;
                            if (!on_q && idle_enough(key_idle_ms, key_need_ms)) begin
                                on_q     = 1'b1;
                                r.change = CHG_ON;
                            end
                            if (ev.off_timeout_ms != '0)
                                off_left_ms = ev.off_timeout_ms;
                        end
                    end
                end
                REQ_KEY_POS: begin
                    if (on_q && rearm_mask[ev.key_position]) begin
                        rearm_wait_q = 1'b1;
                        ptr_idle_ms  = '0;
                    end
                    if (on_q && !excl_mask[ev.key_position]) begin
                        on_q     = 1'b0;
                        r.change = CHG_OFF;
                    end
                end
                REQ_KEYCODE: key_idle_ms = '0;
                REQ_TICK: begin
                    if (key_idle_ms != '1)
                        key_idle_ms++;
                    if (ptr_idle_ms != '1)
                        ptr_idle_ms++;
                    if (off_left_ms != '0) begin
                        off_left_ms--;
                        if (off_left_ms == '0 && on_q) begin
                            on_q     = 1'b0;
                            r.change = CHG_OFF;
                        end
                    end
                end
                REQ_LAYER_CHG: begin
                    if (!ev.layer_still_on) begin
                        on_q        = 1'b0;
                        off_left_ms = '0;
                    end
                end
                default: ;
            endcase
            r.current_layer = layer_q;
            r.layer_on      = on_q;
            return r;
        endfunction

        function void note_event(ev_t ev);
            expected_results.push_back(apply_event(ev));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            res_t got;
            res_t want;
            got.current_layer = beat[4:0];
            got.layer_on      = beat[5];
            got.change        = beat[7:6];
            got.status        = beat[8];
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h", beat);
                return;
            end
            want = expected_results.pop_front();
            if (got.current_layer != want.current_layer || got.layer_on != want.layer_on ||
                got.change != want.change || got.status != want.status) begin
                errors++;
                if (errors <= 10)
                    $display({"result %0d: expected layer %0d on %0b change %0d status %0b,",
                              " got layer %0d on %0b change %0d status %0b"},
                             results_seen, want.current_layer, want.layer_on, want.change,
                             want.status, got.current_layer, got.layer_on, got.change,
                             got.status);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    layer_result_board sb = new();
    int  cycles = 0;
    bit  sender_steady = 1'b0;

    auto_pointer_layer_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result sink: random stalls, some long ready stretches, and two long hold-offs
    // so that both stages fill and s_tready drops.
    initial
    begin : result_sink
        int run_len;
        int hold;
        int next_hold_at;
        next_hold_at = 400;
        @(posedge rst_n);
        forever
        begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(20, 1);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (sb.results_seen >= next_hold_at && next_hold_at < 1500)
            begin
                hold = 300;
                next_hold_at = next_hold_at + 700;
            end
            else
                hold = pick_gap();
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    task automatic send_event(ev_t ev);
        s_tvalid <= 1'b1;
        s_tuser  <= ev.req_type;
        s_tdata  <= {4'b0, ev.layer_still_on, ev.off_timeout_ms, ev.target_layer,
                     ev.key_position};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_event(ev);
    endtask

    task automatic sender_gap();
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_with_gap(ev_t ev);
        send_event(ev);
        sender_gap();
    endtask

    // Waits until every expected result has come out and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(logic [IDLE_CFG_W-1:0] key_need, logic [IDLE_CFG_W-1:0] rearm_need,
                                logic [MASK_W-1:0] excl, logic [MASK_W-1:0] rearm);
        logic [CFG_ADDR_W-1:0] ids  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        ids[0]  = REG_KEY_IDLE;
        ids[1]  = REG_PTR_REARM;
        ids[2]  = REG_EXCL_MASK;
        ids[3]  = REG_REARM_MASK;
        vals[0] = CFG_DATA_W'(key_need);
        vals[1] = CFG_DATA_W'(rearm_need);
        vals[2] = excl;
        vals[3] = rearm;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= ids[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_reg(ids[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic ev_t make_ev(logic [REQ_W-1:0] kind, int pos, int layer, int timeout,
                                    bit still_on);
        ev_t ev;
        ev.req_type       = kind;
        ev.key_position   = POS_W'(pos);
        ev.target_layer   = LAYER_W'(layer);
        ev.off_timeout_ms = COUNT_W'(timeout);
        ev.layer_still_on = still_on;
        return ev;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {$urandom & $urandom, $urandom & $urandom};
            2: return {$urandom | $urandom, $urandom | $urandom};
            default: return MASK_W'(1) << $urandom_range(MASK_W - 1);
        endcase
    endfunction

    // All fields random, then for motion the timeout shaped toward
    // values that move the state.
    function automatic ev_t rand_event(logic [REQ_W-1:0] kind);
        ev_t ev;
        int  r;
        ev = make_ev(kind, $urandom_range(63), $urandom_range(31), $urandom_range(65535),
                     1'($urandom_range(1)));
        if (kind == REQ_MOTION)
        begin
            r = $urandom_range(99);
            if (r < 10)
                ev.off_timeout_ms = '0;
            else if (r < 85)
                ev.off_timeout_ms = COUNT_W'($urandom_range(60, 1));
        end
        return ev;
    endfunction

    task automatic run_random(int count);
        int   done;
        int   pick;
        int   len;
        ev_t  ev;
        logic [REQ_W-1:0] kind;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            len  = 1;
            if (pick < 30)
            begin
                kind = REQ_TICK;
                len  = $urandom_range(40, 1);
            end
            else if (pick < 52)
            begin
                kind = REQ_MOTION;
                len  = $urandom_range(4, 1);
            end
            else if (pick < 72)
                kind = REQ_KEY_POS;
            else if (pick < 82)
                kind = REQ_KEYCODE;
            else if (pick < 90)
                kind = REQ_LAYER_CHG;
            else
                kind = REQ_W'($urandom_range(7));
            for (int i = 0; i < len && done < count; i++)
            begin
                ev = rand_event(kind);
                send_with_gap(ev);
                if (ev.req_type <= REQ_LAYER_CHG)
                    done++;
            end
        end
    endtask

    task automatic run_directed();
        ev_t seq [$];
        seq.push_back(make_ev(REQ_MOTION, 0, 31, 0, 0));      // saturated key counter
        seq.push_back(make_ev(REQ_KEY_POS, 9, 0, 0, 0));      // rearm and excluded
        seq.push_back(make_ev(REQ_MOTION, 0, 0, 65535, 0));   // hold-off not over
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_MOTION, 0, 31, 2, 0));      // hold-off ends
        seq.push_back(make_ev(REQ_KEYCODE, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_KEY_POS, 5, 0, 0, 0));      // excluded only
        seq.push_back(make_ev(REQ_KEY_POS, 7, 0, 0, 0));      // rearm only, turns off
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));         // countdown ends while off
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_MOTION, 0, 17, 3, 0));
        seq.push_back(make_ev(REQ_KEY_POS, 63, 0, 0, 0));     // off, countdown keeps going
        seq.push_back(make_ev(REQ_MOTION, 0, 17, 1, 0));
        seq.push_back(make_ev(REQ_TICK, 0, 0, 0, 0));         // countdown expiry turns off
        seq.push_back(make_ev(REQ_MOTION, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_LAYER_CHG, 0, 0, 0, 1));
        seq.push_back(make_ev(REQ_LAYER_CHG, 0, 0, 0, 0));    // external off
        seq.push_back(make_ev(REQ_W'(5), 63, 31, 65535, 1));
        seq.push_back(make_ev(REQ_W'(6), 63, 31, 65535, 1));
        seq.push_back(make_ev(REQ_W'(7), 63, 31, 65535, 1));
        seq.push_back(make_ev(REQ_KEY_POS, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_KEYCODE, 0, 0, 0, 0));
        seq.push_back(make_ev(REQ_MOTION, 0, 0, 0, 0));       // keyboard not idle yet
        foreach (seq[i])
            send_with_gap(seq[i]);
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        program_regs(15'd3, 15'd2, 64'h0000_0000_0000_0220, 64'h0000_0000_0000_0280);
        run_directed();
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: program_regs('0, '0, '0, '0);
                1: program_regs('1, '1, '1, '1);
                2: program_regs('0, '1, rand_mask(), '1);
                default: program_regs(IDLE_CFG_W'($urandom_range(25)),
                                      IDLE_CFG_W'($urandom_range(25)),
                                      rand_mask(), rand_mask());
            endcase
            sender_steady = (phase % 3 == 2);
            run_random(200);
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/apl_pkg.sv
hw/rtl/apl_cfg_regs.sv
hw/rtl/apl_core.sv
hw/rtl/auto_pointer_layer_controller_top.sv
tb/sv/auto_pointer_layer_controller_top_test.sv
